// ===== rtl/dbq_pkg.sv =====
// Shared types and constants for the button debounce qualifier.
package dbq_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TICK_W      = 16;
  localparam int CMP_W       = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_TICKS   = 1'b0,
    REG_RELEASE_TICKS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_RELEASED = 2'd1,
    MODE_PRESSED  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  typedef struct packed {
    logic cmd;
    logic pin_level;
  } in_t;

  typedef struct packed {
    event_t event_res;
    mode_t  settled_mode;
  } out_t;

  typedef struct packed {
    logic [TICK_W-1:0] press_ticks;
    logic [TICK_W-1:0] release_ticks;
  } cfg_t;

endpackage

// ===== rtl/dbq_core.sv =====
// Debounce state registers and the single-pass update for one beat.
module dbq_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  dbq_pkg::in_t  item,
  input  dbq_pkg::cfg_t cfg,
  output dbq_pkg::out_t res
);

  dbq_pkg::mode_t                  mode_r, mode_nxt;
  logic [dbq_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                            rst_low_r, rst_low_nxt;
  logic                            rst_high_r, rst_high_nxt;

  logic                            low;
  logic                            is_init;
  logic                            count_up;
  logic [dbq_pkg::COUNT_WIDTH-1:0] cnt_base;
  logic [dbq_pkg::COUNT_WIDTH-1:0] cnt_inc;
  logic [dbq_pkg::TICK_W-1:0]      ticks;
  logic                            reached;

  always_comb begin
    low      = ~item.pin_level;
    is_init  = 1'b1;
    count_up = 1'b1;
    unique case (mode_r)
      dbq_pkg::MODE_RELEASED: begin
        is_init  = 1'b0;
        count_up = low;
      end
      dbq_pkg::MODE_PRESSED: begin
        is_init  = 1'b0;
        count_up = ~low;
      end
      default: begin
        is_init  = 1'b1;
        count_up = 1'b1;
      end
    endcase

    // While initialising, a change of level starts the run count afresh.
    if (is_init && ((low && rst_low_r) || (!low && rst_high_r))) begin
      cnt_base = '0;
    end else begin
      cnt_base = cnt_r;
    end
    cnt_inc = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
    ticks   = low ? cfg.press_ticks : cfg.release_ticks;
    reached = dbq_pkg::CMP_W'(cnt_inc) >= dbq_pkg::CMP_W'(ticks);

    mode_nxt         = mode_r;
    cnt_nxt          = cnt_r;
    rst_low_nxt      = rst_low_r;
    rst_high_nxt     = rst_high_r;
    res.event_res    = dbq_pkg::EV_NONE;

    if (item.cmd) begin
      mode_nxt     = dbq_pkg::MODE_INIT;
      cnt_nxt      = '0;
      rst_low_nxt  = 1'b1;
      rst_high_nxt = 1'b1;
    end else begin
      if (is_init) begin
        rst_low_nxt  = ~low;
        rst_high_nxt = low;
      end
      if (count_up) begin
        if (reached) begin
          cnt_nxt       = '0;
          mode_nxt      = low ? dbq_pkg::MODE_PRESSED : dbq_pkg::MODE_RELEASED;
          res.event_res = low ? dbq_pkg::EV_PRESS : dbq_pkg::EV_RELEASE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end else begin
        cnt_nxt = (cnt_r == '0) ? cnt_r : cnt_r - 1'b1;
      end
    end
    res.settled_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= dbq_pkg::MODE_INIT;
      cnt_r      <= '0;
      rst_low_r  <= 1'b1;
      rst_high_r <= 1'b1;
    end else if (advance) begin
      mode_r     <= mode_nxt;
      cnt_r      <= cnt_nxt;
      rst_low_r  <= rst_low_nxt;
      rst_high_r <= rst_high_nxt;
    end
  end

endmodule

// ===== rtl/button_debounce_qualifier.sv =====
// Top level of the button debounce qualifier: beat stages, registers and checks.
//
// Each input beat carries one sample of an active-low button pin, or a restart
// command that returns the debouncer to its initialising mode. Every input beat
// produces exactly one result beat giving the event (none, press, release) and
// the settled mode after that sample.
// Beats move on valid/ready handshakes. An accepted beat is held in an input
// register; once the output register is empty or being drained, the debounce
// update runs and its result is registered in the output register, where
// out_valid announces it until the receiver takes it.
// Throughput is one beat per cycle: the input register empties into the
// output register whenever that register is empty or being drained.
// When the receiver stalls, the result stays in the output register, one more
// beat waits in the input register and in_ready then drops; nothing is lost.
// The press and release thresholds are counted in sample ticks and are set
// through the write port (index 0 press, index 1 release); both reset to 20.
// Synchronous reset empties both registers and puts the debouncer in its
// initialising mode with a zero count.
module button_debounce_qualifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dbq_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dbq_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [dbq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic          stg_vld_r;
  dbq_pkg::in_t  stg_data_r;
  logic          out_vld_r;
  dbq_pkg::out_t out_data_r;
  dbq_pkg::cfg_t cfg_r;
  dbq_pkg::out_t res;
  logic          advance;

  // The held beat moves on when the output register is free or draining.
  assign advance   = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !stg_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_ticks   <= dbq_pkg::TICK_W'(20);
      cfg_r.release_ticks <= dbq_pkg::TICK_W'(20);
    end else if (cfg_we) begin
      unique case (dbq_pkg::cfg_reg_t'(cfg_index))
        dbq_pkg::REG_PRESS_TICKS:   cfg_r.press_ticks   <= dbq_pkg::TICK_W'(cfg_wdata);
        dbq_pkg::REG_RELEASE_TICKS: cfg_r.release_ticks <= dbq_pkg::TICK_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  dbq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (stg_data_r),
    .cfg     (cfg_r),
    .res     (res)
  );

`ifndef SYNTH
  // A restart beat always reports the initialising mode with no event.
  a_restart_result : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_data_r.cmd) |=>
      (out_data.settled_mode == dbq_pkg::MODE_INIT &&
       out_data.event_res == dbq_pkg::EV_NONE))
    else $error("restart beat did not yield initialising result");

  // An event always agrees with the mode it settles into.
  a_event_mode : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_res != dbq_pkg::EV_NONE) |->
      ((out_data.event_res == dbq_pkg::EV_PRESS &&
        out_data.settled_mode == dbq_pkg::MODE_PRESSED) ||
       (out_data.event_res == dbq_pkg::EV_RELEASE &&
        out_data.settled_mode == dbq_pkg::MODE_RELEASED)))
    else $error("event does not match settled mode");

  // With the output register empty, the input side must never be blocked.
  a_no_false_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled while output register empty");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the button debounce qualifier, with its scoreboard and drivers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // If nothing moves on either channel for this many cycles, the run is stuck.
  // The longest legal quiet spell is the long receiver hold-off plus an idle burst
  // and a drain pause, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 2000;
  // Length of the deliberate receiver hold-off used to back the block up.
  localparam int unsigned LONG_HOLD = 300;
  // Results are offered from the output register once each held beat moves on,
  // so a handful of cycles after the last expected beat lets anything stray show up.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Keep the log readable if something goes badly wrong.
  localparam int unsigned MAX_PRINTED = 100;

  // Scoreboard: a model of the debouncer that turns each accepted input beat
  // into the result beat the block should produce, and compares each result
  // beat against the oldest outstanding prediction.
  class debounce_scoreboard;
    dbq_pkg::mode_t                  mode;
    logic [dbq_pkg::COUNT_WIDTH-1:0] samples;
    bit                              rearm_low;
    bit                              rearm_high;
    logic [dbq_pkg::TICK_W-1:0]      press_thr;
    logic [dbq_pkg::TICK_W-1:0]      release_thr;
    dbq_pkg::out_t                   predicted_q[$];
    int unsigned                     mismatches;

    function new();
      mode        = dbq_pkg::MODE_INIT;
      samples     = '0;
      rearm_low   = 1'b1;
      rearm_high  = 1'b1;
      press_thr   = dbq_pkg::TICK_W'(20);
      release_thr = dbq_pkg::TICK_W'(20);
      mismatches  = 0;
    endfunction

    function void set_threshold(dbq_pkg::cfg_reg_t idx, logic [dbq_pkg::TICK_W-1:0] value);
      if (idx == dbq_pkg::REG_PRESS_TICKS) begin
        press_thr = value;
      end else begin
        release_thr = value;
      end
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction

    // The count saturates rather than wrapping.
    function void tick_up();
      if (samples != '1) begin
        samples = samples + 1'b1;
      end
    endfunction

    function void tick_down();
      if (samples != '0) begin
        samples = samples - 1'b1;
      end
    endfunction

    // Called after a count-up: if the threshold is met the mode flips and
    // the count starts again from zero. A zero threshold is met at once.
    function dbq_pkg::event_t try_settle(logic [dbq_pkg::TICK_W-1:0] thr,
                                         dbq_pkg::mode_t to_mode, dbq_pkg::event_t ev);
      if (64'(samples) >= 64'(thr)) begin
        samples = '0;
        mode    = to_mode;
        return ev;
      end
      return dbq_pkg::EV_NONE;
    endfunction

    function void note_input(dbq_pkg::in_t beat);
      dbq_pkg::out_t res;
      bit            low;
      low           = (beat.pin_level == 1'b0);
      res.event_res = dbq_pkg::EV_NONE;
      if (beat.cmd) begin
        // Restart: the pin level of this beat plays no part.
        samples    = '0;
        mode       = dbq_pkg::MODE_INIT;
        rearm_low  = 1'b1;
        rearm_high = 1'b1;
      end else begin
        unique case (mode)
          dbq_pkg::MODE_RELEASED: begin
            if (low) begin
              tick_up();
              res.event_res = try_settle(press_thr, dbq_pkg::MODE_PRESSED, dbq_pkg::EV_PRESS);
            end else begin
              tick_down();
            end
          end
          dbq_pkg::MODE_PRESSED: begin
            if (!low) begin
              tick_up();
              res.event_res = try_settle(release_thr, dbq_pkg::MODE_RELEASED,
                                         dbq_pkg::EV_RELEASE);
            end else begin
              tick_down();
            end
          end
          default: begin
            // Initialising: the count follows the current run of equal levels.
            if (low) begin
              if (rearm_low) begin
                rearm_low = 1'b0;
                samples   = '0;
              end
              rearm_high = 1'b1;
              tick_up();
              res.event_res = try_settle(press_thr, dbq_pkg::MODE_PRESSED, dbq_pkg::EV_PRESS);
            end else begin
              if (rearm_high) begin
                rearm_high = 1'b0;
                samples    = '0;
              end
              rearm_low = 1'b1;
              tick_up();
              res.event_res = try_settle(release_thr, dbq_pkg::MODE_RELEASED,
                                         dbq_pkg::EV_RELEASE);
            end
          end
        endcase
      end
      res.settled_mode = mode;
      predicted_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    task check_result(dbq_pkg::out_t got);
      dbq_pkg::out_t want;
      if (predicted_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: event %0d mode %0d",
                                  got.event_res, got.settled_mode));
        return;
      end
      want = predicted_q.pop_front();
      if (got.event_res !== want.event_res) begin
        report_mismatch($sformatf("event_res got %0d want %0d", got.event_res,
                                  want.event_res));
      end
      if (got.settled_mode !== want.settled_mode) begin
        report_mismatch($sformatf("settled_mode got %0d want %0d", got.settled_mode,
                                  want.settled_mode));
      end
    endtask

    task check_leftovers();
      if (predicted_q.size() != 0) begin
        report_mismatch($sformatf("%0d predicted result beats never arrived",
                                  predicted_q.size()));
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  dbq_pkg::in_t                    in_data;
  logic                            out_valid;
  logic                            out_ready;
  dbq_pkg::out_t                   out_data;
  logic                            cfg_we;
  logic [dbq_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [dbq_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  debounce_scoreboard     sb;
  // Shared between the stimulus process and the receiver: idle_on enables
  // random gaps on both sides, long_hold asks the receiver for a long stall.
  bit                     idle_on = 1'b1;
  bit                     long_hold = 1'b0;
  int unsigned            quiet_cycles = 0;

  button_debounce_qualifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor. Everything the testbench drives changes through nonblocking
  // assignments at the rising edge, and the block's outputs only move in the
  // NBA region, so the values read here are the ones the edge itself sees.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  // Watchdog: counts edges at which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no beat moved for %0d cycles", $realtime, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver. Mostly ready, with random stall bursts while idle_on is set.
  // On request it holds off for a long stall counted here by LONG_HOLD, so that the
  // block fills both of its stages and has to drop in_ready.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one beat and returns in the time step of the edge that accepts it.
  // Must be entered in the time step of a rising edge. Valid is left high so
  // that a following beat can go out back to back.
  task automatic send_beat(bit restart_cmd, bit level);
    dbq_pkg::in_t beat;
    beat.cmd       = restart_cmd;
    beat.pin_level = level;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every predicted result beat has come back, then a few
  // more cycles so the block is certainly idle before the next write.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both thresholds on consecutive cycles; the block must be idle.
  task automatic set_thresholds(logic [dbq_pkg::TICK_W-1:0] press_v,
                                logic [dbq_pkg::TICK_W-1:0] release_v);
    cfg_we    <= 1'b1;
    cfg_index <= dbq_pkg::REG_PRESS_TICKS;
    cfg_wdata <= press_v;
    sb.set_threshold(dbq_pkg::REG_PRESS_TICKS, press_v);
    @(posedge clk);
    cfg_index <= dbq_pkg::REG_RELEASE_TICKS;
    cfg_wdata <= release_v;
    sb.set_threshold(dbq_pkg::REG_RELEASE_TICKS, release_v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random stimulus shaped like a real bouncing button: runs of a steady
  // level of random length up to max_run, with single-sample glitches
  // against the run and the occasional restart command thrown in.
  task automatic run_phase(int unsigned n_items, int unsigned max_run);
    bit          level;
    int unsigned run_left;
    bit          glitch;
    level    = 1'($urandom_range(0, 1));
    run_left = 0;
    repeat (n_items) begin
      if (run_left == 0) begin
        level    = ~level;
        run_left = $urandom_range(1, max_run);
      end
      run_left--;
      glitch = ($urandom_range(0, 99) < 10);
      send_beat($urandom_range(0, 99) < 3, glitch ? ~level : level);
    end
    in_valid <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    logic [dbq_pkg::TICK_W-1:0] p_thr;
    logic [dbq_pkg::TICK_W-1:0] r_thr;
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= dbq_pkg::REG_PRESS_TICKS;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Thresholds as they come out of reset (20 ticks each).
    run_phase(90, 45);
    wait_drained();

    // Directed: zero thresholds flip on the very first disagreeing sample,
    // and an agreeing sample at zero count leaves the count at zero.
    set_thresholds('0, '0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Directed: level changes while initialising restart the count; then in
    // the settled modes agreeing samples count back down towards zero.
    set_thresholds(16'd3, 16'd2);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Thresholds of one, then each one at its top value in turn.
    set_thresholds(16'd1, 16'd1);
    run_phase(100, 4);
    wait_drained();
    set_thresholds(16'hFFFF, 16'd1);
    run_phase(80, 10);
    wait_drained();
    set_thresholds(16'd1, 16'hFFFF);
    run_phase(80, 10);
    wait_drained();

    // Random small thresholds. The second of these phases also backs the
    // block up with a long receiver stall while the sender keeps offering.
    for (int ph = 0; ph < 4; ph++) begin
      p_thr = dbq_pkg::TICK_W'($urandom_range(1, 12));
      r_thr = dbq_pkg::TICK_W'($urandom_range(1, 12));
      set_thresholds(p_thr, r_thr);
      if (ph == 1) begin
        long_hold = 1'b1;
      end
      run_phase(90, 2 * ((p_thr > r_thr) ? p_thr : r_thr) + 3);
      wait_drained();
    end

    // Both thresholds at the all-ones value: short unbroken runs never
    // settle, so the mode stays initialising while the count follows each
    // run. Streamed without gaps from here to the end.
    idle_on = 1'b0;
    set_thresholds(16'hFFFF, 16'hFFFF);
    send_beat(1'b1, 1'b1);
    repeat (20) send_beat(1'b0, 1'b0);
    repeat (20) send_beat(1'b0, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Final stretch with no idling on either side.
    set_thresholds(16'd5, 16'd7);
    run_phase(100, 17);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_leftovers();
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
